// File: rtl/bic_pkg.sv
`default_nettype none

package bic_pkg;

   // Fixed field widths
   localparam int SAMPLE_W = 32;
   localparam int COORD_W  = 32;
   localparam int DIFF_W   = COORD_W + 1;   // signed coordinate difference
   localparam int MAG_W    = COORD_W + 1;   // magnitude of a difference

   // Coordinate format and longitude wrap limits
   localparam int COORD_FRAC_BITS = 20;
   localparam int WRAP_W          = MAG_W + 2;
   localparam logic [WRAP_W-1:0] DEG180 = WRAP_W'(180) << COORD_FRAC_BITS;
   localparam logic [WRAP_W-1:0] DEG360 = WRAP_W'(360) << COORD_FRAC_BITS;

   // Near-zero divisor limits: 1e-9 degree and 1e-9 square degree, rounded up
   localparam longint unsigned TINY_LIN_L =
      ((64'd1 << COORD_FRAC_BITS) + 64'd999999999) / 64'd1000000000;
   localparam longint unsigned TINY_SQ_L =
      ((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd999999999) / 64'd1000000000;
   localparam logic [MAG_W-1:0] TINY_LIN = MAG_W'(TINY_LIN_L);
   localparam logic [63:0]      TINY_SQ  = 64'(TINY_SQ_L);

   // Ratio format: 22 fraction bits, saturated to +-8.0
   localparam int RATIO_FRAC = 22;
   localparam int QUO_W      = RATIO_FRAC + 4;          // holds 8.0
   localparam logic [QUO_W-1:0] RATIO_MAX = QUO_W'(8) << RATIO_FRAC;
   localparam int RATIO_W    = QUO_W + 1;               // signed ratio
   localparam int DIV_LAT    = QUO_W + 1;               // setup stage + one per bit

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_LOW  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_HIGH = 1'd1;

   // Classified item handed from front to back
   typedef struct packed {
      logic                       bypass;   // result is g0 as is
      logic                       flag;     // all four corners bad
      logic signed [SAMPLE_W-1:0] g0;
      logic signed [SAMPLE_W-1:0] g1;
      logic signed [SAMPLE_W-1:0] g2;
      logic signed [SAMPLE_W-1:0] g3;
      logic [MAG_W-1:0]           x_num;
      logic [MAG_W-1:0]           x_den;
      logic [MAG_W-1:0]           y_num;
      logic [MAG_W-1:0]           y_den;
      logic                       x_neg;    // sign of u
      logic                       y_neg;    // sign of v
   } bic_item_type;

   // Per-item data carried alongside the dividers
   typedef struct packed {
      logic                         bypass;
      logic                         flag;
      logic signed [SAMPLE_W-1:0]   g0;
      logic signed [SAMPLE_W:0]     d30;    // g3 - g0
      logic signed [SAMPLE_W:0]     d10;    // g1 - g0
      logic signed [SAMPLE_W+1:0]   gs;     // g0 - g1 + g2 - g3
      logic                         use_u;
      logic                         use_v;
      logic                         nz_xy;  // both spans nonzero
      logic                         big;    // a span at or above 2^31
      logic [30:0]                  x_lo;
      logic [30:0]                  y_lo;
      logic                         x_neg;
      logic                         y_neg;
   } bic_bk_type;

   function automatic logic [MAG_W-1:0] mag33(input logic signed [DIFF_W-1:0] x);
      return x[DIFF_W-1] ? MAG_W'(-x) : MAG_W'(x);
   endfunction

   // Longitude span magnitude folded past 180 degrees
   function automatic logic [MAG_W-1:0] wrap_mag(input logic [MAG_W-1:0] m);
      logic signed [WRAP_W-1:0] r;
      r = $signed(DEG360) - $signed(WRAP_W'(m));
      if (WRAP_W'(m) > DEG180)
         return r[WRAP_W-1] ? MAG_W'(-r) : MAG_W'(r);
      return m;
   endfunction

   // Mean of two samples, ties away from zero
   function automatic logic signed [SAMPLE_W-1:0] mean2(input logic signed [SAMPLE_W-1:0] a,
                                                        input logic signed [SAMPLE_W-1:0] b);
      logic signed [SAMPLE_W:0] s;
      logic [SAMPLE_W:0]        m;
      s = (SAMPLE_W+1)'(a) + (SAMPLE_W+1)'(b);
      m = s[SAMPLE_W] ? (SAMPLE_W+1)'(-s) : (SAMPLE_W+1)'(s);
      m = (m + (SAMPLE_W+1)'(1)) >> 1;
      return s[SAMPLE_W] ? SAMPLE_W'(-$signed(m)) : SAMPLE_W'(m);
   endfunction

   // Drop RATIO_FRAC fraction bits, ties away from zero; |x| < 2^62
   function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] x);
      logic [63:0] m;
      m = x[63] ? 64'(-x) : 64'(x);
      m = (m + (64'd1 << (RATIO_FRAC - 1))) >> RATIO_FRAC;
      return x[63] ? -$signed(m) : $signed(m);
   endfunction

endpackage

`default_nettype wire

// File: rtl/bilinear_interp_missing_corner_fill.sv
// Throughput: one item per cycle unless stalled; the restoring divider for
// the cell ratios is fully pipelined: setup, then one quotient bit per stage.
// A four-entry queue separates front and back so each side stalls on its own.
// Reset (synchronous, active high) empties the pipeline and queue and sets
// the valid range to the full 32-bit span.
`default_nettype none

module bilinear_interp_missing_corner_fill import bic_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [SAMPLE_W-1:0]        csr_write_data,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [COORD_W-1:0]  req_query_lat,
   input  wire logic signed [COORD_W-1:0]  req_query_lon,
   input  wire logic signed [COORD_W-1:0]  req_cell_low_lat,
   input  wire logic signed [COORD_W-1:0]  req_cell_low_lon,
   input  wire logic signed [COORD_W-1:0]  req_cell_high_lat,
   input  wire logic signed [COORD_W-1:0]  req_cell_high_lon,
   input  wire logic signed [SAMPLE_W-1:0] req_corner_lower_left,
   input  wire logic signed [SAMPLE_W-1:0] req_corner_upper_left,
   input  wire logic signed [SAMPLE_W-1:0] req_corner_upper_right,
   input  wire logic signed [SAMPLE_W-1:0] req_corner_lower_right,
   input  wire logic signed [SAMPLE_W-1:0] req_default_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0]      rsp_interpolated_value,
   output logic                            rsp_all_corners_bad
);

   logic         push, q_full, q_pop, q_empty;
   bic_item_type push_item, q_head;

   bic_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_query_lat          (req_query_lat),
      .req_query_lon          (req_query_lon),
      .req_cell_low_lat       (req_cell_low_lat),
      .req_cell_low_lon       (req_cell_low_lon),
      .req_cell_high_lat      (req_cell_high_lat),
      .req_cell_high_lon      (req_cell_high_lon),
      .req_corner_lower_left  (req_corner_lower_left),
      .req_corner_upper_left  (req_corner_upper_left),
      .req_corner_upper_right (req_corner_upper_right),
      .req_corner_lower_right (req_corner_lower_right),
      .req_default_value      (req_default_value),
      .push                   (push),
      .push_item              (push_item),
      .q_full                 (q_full)
   );

   bic_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   bic_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_valid                (!q_empty),
      .q_item                 (q_head),
      .q_pop                  (q_pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_interpolated_value (rsp_interpolated_value),
      .rsp_all_corners_bad    (rsp_all_corners_bad)
   );

endmodule

`default_nettype wire

// File: rtl/bic_div.sv
`default_nettype none

// Pipelined restoring divider: |num| * 2^22 / |den|, rounded, saturated to 8.0
module bic_div import bic_pkg::*; (
   input  wire logic             clock,
   input  wire logic             adv,
   input  wire logic [MAG_W-1:0] num,
   input  wire logic [MAG_W-1:0] den,
   output logic      [QUO_W-1:0] quo
);

   localparam int N_W  = MAG_W + RATIO_FRAC + 1;
   localparam int HI_W = N_W - QUO_W;

   logic [MAG_W-1:0] rem_ff [0:QUO_W];
   logic [MAG_W-1:0] den_ff [0:QUO_W];
   logic [QUO_W-1:0] low_ff [0:QUO_W];
   logic [QUO_W-1:0] q_ff   [0:QUO_W];
   logic             sat_ff [0:QUO_W];

   logic [N_W-1:0]   n_in;
   logic [HI_W-1:0]  hi_in;

   // Setup: numerator with rounding half, overflow check on the top part
   always_comb begin
      n_in  = (N_W'(num) << RATIO_FRAC) + N_W'(den >> 1);
      hi_in = n_in[N_W-1:QUO_W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= MAG_W'(hi_in);
         den_ff[0] <= den;
         low_ff[0] <= n_in[QUO_W-1:0];
         q_ff[0]   <= '0;
         sat_ff[0] <= MAG_W'(hi_in) >= den;
      end
   end

   // One quotient bit per stage
   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      logic [MAG_W:0] t;
      logic           ge;
      always_comb begin
         t  = {rem_ff[k-1], low_ff[k-1][QUO_W-1]};
         ge = t >= {1'b0, den_ff[k-1]};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= ge ? MAG_W'(t - {1'b0, den_ff[k-1]}) : t[MAG_W-1:0];
            den_ff[k] <= den_ff[k-1];
            low_ff[k] <= low_ff[k-1] << 1;
            q_ff[k]   <= {q_ff[k-1][QUO_W-2:0], ge};
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   assign quo = (sat_ff[QUO_W] || q_ff[QUO_W] > RATIO_MAX) ? RATIO_MAX : q_ff[QUO_W];

endmodule

`default_nettype wire

// File: rtl/bic_queue.sv
`default_nettype none

module bic_queue import bic_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire bic_item_type push_item,
   output logic              full,
   input  wire logic         pop,
   output logic              empty,
   output bic_item_type      head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   bic_item_type     mem_ff [0:QUEUE_DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head  = mem_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue push while full");
   a_no_underflow : assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue pop while empty");
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

`default_nettype wire

// File: rtl/bic_front.sv
`default_nettype none

// Front: range check, corner repair, coordinate spans; two stages
module bic_front import bic_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [SAMPLE_W-1:0]        csr_write_data,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [COORD_W-1:0]  req_query_lat,
   input  wire logic signed [COORD_W-1:0]  req_query_lon,
   input  wire logic signed [COORD_W-1:0]  req_cell_low_lat,
   input  wire logic signed [COORD_W-1:0]  req_cell_low_lon,
   input  wire logic signed [COORD_W-1:0]  req_cell_high_lat,
   input  wire logic signed [COORD_W-1:0]  req_cell_high_lon,
   input  wire logic signed [SAMPLE_W-1:0] req_corner_lower_left,
   input  wire logic signed [SAMPLE_W-1:0] req_corner_upper_left,
   input  wire logic signed [SAMPLE_W-1:0] req_corner_upper_right,
   input  wire logic signed [SAMPLE_W-1:0] req_corner_lower_right,
   input  wire logic signed [SAMPLE_W-1:0] req_default_value,
   output logic                            push,
   output bic_item_type                    push_item,
   input  wire logic                       q_full
);

   // Bad-corner pairs; bit 0 lower-left, 1 upper-left, 2 upper-right, 3 lower-right
   localparam logic [3:0] BAD_LL_UL = 4'b0011;
   localparam logic [3:0] BAD_LL_UR = 4'b0101;
   localparam logic [3:0] BAD_LL_LR = 4'b1001;
   localparam logic [3:0] BAD_UL_UR = 4'b0110;
   localparam logic [3:0] BAD_UL_LR = 4'b1010;

   logic signed [SAMPLE_W-1:0] valid_low_ff, valid_high_ff;

   logic                       f1_valid_ff;
   logic signed [SAMPLE_W-1:0] f1_g_ff [0:3];
   logic [3:0]                 f1_bad_ff;
   logic signed [SAMPLE_W-1:0] f1_def_ff;
   logic [MAG_W-1:0]           f1_xm_ff, f1_dxm_ff, f1_ym_ff, f1_dym_ff;
   logic                       f1_xneg_ff, f1_yneg_ff;

   logic                       f2_valid_ff;
   bic_item_type               f2_item_ff;

   logic                       fen;
   logic signed [SAMPLE_W-1:0] lo, hi;
   logic signed [SAMPLE_W-1:0] g_in [0:3];
   logic [3:0]                 bad_in;
   logic signed [DIFF_W-1:0]   xp, yp, dx, dy;

   logic [2:0]                 nbad;
   logic signed [SAMPLE_W-1:0] rg [0:3];
   logic signed [SAMPLE_W-1:0] good;
   bic_item_type               item_in;

   // Front advances unless a finished item cannot enter the queue
   assign fen       = !f2_valid_ff || !q_full;
   assign req_stall = !fen;
   assign push      = f2_valid_ff && !q_full;
   assign push_item = f2_item_ff;

   // Range registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_low_ff  <= {1'b1, {(SAMPLE_W-1){1'b0}}};
         valid_high_ff <= {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_VALID_LOW:  valid_low_ff  <= csr_write_data;
            CSR_VALID_HIGH: valid_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Stage 1: range check and raw spans
   always_comb begin
      lo = (valid_low_ff > valid_high_ff) ? valid_high_ff : valid_low_ff;
      hi = (valid_low_ff > valid_high_ff) ? valid_low_ff : valid_high_ff;
      g_in[0] = req_corner_lower_left;
      g_in[1] = req_corner_upper_left;
      g_in[2] = req_corner_upper_right;
      g_in[3] = req_corner_lower_right;
      for (int i = 0; i < 4; i++) begin
         bad_in[i] = g_in[i] < lo || g_in[i] > hi;
      end
      xp = DIFF_W'(req_query_lon) - DIFF_W'(req_cell_low_lon);
      yp = DIFF_W'(req_query_lat) - DIFF_W'(req_cell_low_lat);
      dx = DIFF_W'(req_cell_high_lon) - DIFF_W'(req_cell_low_lon);
      dy = DIFF_W'(req_cell_high_lat) - DIFF_W'(req_cell_low_lat);
   end

   always_ff @(posedge clock) begin
      if (fen) begin
         for (int i = 0; i < 4; i++) f1_g_ff[i] <= g_in[i];
         f1_bad_ff  <= bad_in;
         f1_def_ff  <= req_default_value;
         f1_xm_ff   <= mag33(xp);
         f1_dxm_ff  <= mag33(dx);
         f1_ym_ff   <= mag33(yp);
         f1_dym_ff  <= mag33(dy);
         f1_xneg_ff <= xp[DIFF_W-1] ^ dx[DIFF_W-1];
         f1_yneg_ff <= yp[DIFF_W-1] ^ dy[DIFF_W-1];
      end
   end

   // Stage 2: corner repair, classification, longitude wrap
   always_comb begin
      nbad = 3'(f1_bad_ff[0]) + 3'(f1_bad_ff[1]) + 3'(f1_bad_ff[2]) + 3'(f1_bad_ff[3]);
      for (int i = 0; i < 4; i++) rg[i] = f1_g_ff[i];
      good = f1_g_ff[0];
      for (int i = 0; i < 4; i++) begin
         if (!f1_bad_ff[i]) good = f1_g_ff[i];
      end
      unique case (nbad)
         3'd1: begin
            for (int i = 0; i < 4; i++) begin
               if (f1_bad_ff[i]) rg[i] = mean2(f1_g_ff[(i+1) & 3], f1_g_ff[(i+3) & 3]);
            end
         end
         3'd2: begin
            unique case (f1_bad_ff)
               BAD_LL_UL: begin rg[0] = f1_g_ff[3]; rg[1] = f1_g_ff[2]; end
               BAD_LL_UR: begin rg[0] = f1_g_ff[3]; rg[2] = f1_g_ff[1]; end
               BAD_LL_LR: begin rg[0] = f1_g_ff[1]; rg[3] = f1_g_ff[2]; end
               BAD_UL_UR: begin rg[1] = f1_g_ff[0]; rg[2] = f1_g_ff[3]; end
               BAD_UL_LR: begin rg[1] = f1_g_ff[2]; rg[3] = f1_g_ff[0]; end
               default:   begin rg[2] = f1_g_ff[1]; rg[3] = f1_g_ff[0]; end
            endcase
         end
         default: ;
      endcase

      item_in.bypass = nbad >= 3'd3;
      item_in.flag   = nbad == 3'd4;
      item_in.g0     = (nbad == 3'd4) ? f1_def_ff : ((nbad == 3'd3) ? good : rg[0]);
      item_in.g1     = rg[1];
      item_in.g2     = rg[2];
      item_in.g3     = rg[3];
      item_in.x_num  = wrap_mag(f1_xm_ff);
      item_in.x_den  = wrap_mag(f1_dxm_ff);
      item_in.y_num  = f1_ym_ff;
      item_in.y_den  = f1_dym_ff;
      item_in.x_neg  = f1_xneg_ff;
      item_in.y_neg  = f1_yneg_ff;
   end

   always_ff @(posedge clock) begin
      if (fen) f2_item_ff <= item_in;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (fen) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bic_back.sv
`default_nettype none

// Back: ratio dividers, blend products, sum and saturation
module bic_back import bic_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  wire bic_item_type         q_item,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_interpolated_value,
   output logic                      rsp_all_corners_bad
);

   localparam int PU_W  = SAMPLE_W + 1 + RATIO_W;
   localparam int UVP_W = 2 * RATIO_W;
   localparam int TU_W  = PU_W - RATIO_FRAC + 2;
   localparam int UV_W  = UVP_W - RATIO_FRAC + 2;
   localparam int S_W   = TU_W + 2;

   logic              adv;
   bic_bk_type        bk_in;
   logic [QUO_W-1:0]  qu, qv;

   bic_bk_type        pl_ff [0:DIV_LAT-1];
   logic              pv_ff [0:DIV_LAT-1];

   logic                      m0_valid_ff;
   bic_bk_type                m0_bk_ff;
   logic signed [RATIO_W-1:0] m0_u_ff, m0_v_ff;

   logic                        m1_valid_ff, m1_bypass_ff, m1_flag_ff;
   logic                        m1_use_u_ff, m1_use_v_ff, m1_nz_ff, m1_big_ff;
   logic signed [SAMPLE_W-1:0]  m1_g0_ff;
   logic signed [SAMPLE_W+1:0]  m1_gs_ff;
   logic signed [PU_W-1:0]      m1_pu_ff, m1_pv_ff;
   logic signed [UVP_W-1:0]     m1_uvp_ff;
   logic [61:0]                 m1_tp_ff;

   logic                        m2_valid_ff, m2_bypass_ff, m2_flag_ff;
   logic signed [SAMPLE_W-1:0]  m2_g0_ff;
   logic signed [SAMPLE_W+1:0]  m2_gs_ff;
   logic signed [TU_W-1:0]      m2_tu_ff, m2_tv_ff;
   logic signed [UV_W-1:0]      m2_uv_ff;

   logic                        m3_valid_ff, m3_bypass_ff, m3_flag_ff;
   logic signed [SAMPLE_W-1:0]  m3_g0_ff;
   logic signed [S_W-1:0]       m3_s1_ff;
   logic signed [63:0]          m3_pw_ff;

   logic                        rsp_valid_ff, rsp_flag_ff;
   logic signed [SAMPLE_W-1:0]  rsp_value_ff;

   logic signed [63:0]          tu_r, tv_r, uv_r, tw_r;
   logic                        use_uv;
   logic signed [S_W:0]         res;
   logic signed [SAMPLE_W-1:0]  res_sat;

   // Whole back end moves together; the output register frees it
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv && q_valid;

   // Differences and span flags of the queue head
   always_comb begin
      bk_in.bypass = q_item.bypass;
      bk_in.flag   = q_item.flag;
      bk_in.g0     = q_item.g0;
      bk_in.d30    = (SAMPLE_W+1)'(q_item.g3) - (SAMPLE_W+1)'(q_item.g0);
      bk_in.d10    = (SAMPLE_W+1)'(q_item.g1) - (SAMPLE_W+1)'(q_item.g0);
      bk_in.gs     = (SAMPLE_W+2)'(q_item.g0) - (SAMPLE_W+2)'(q_item.g1)
                   + (SAMPLE_W+2)'(q_item.g2) - (SAMPLE_W+2)'(q_item.g3);
      bk_in.use_u  = q_item.x_den >= TINY_LIN;
      bk_in.use_v  = q_item.y_den >= TINY_LIN;
      bk_in.nz_xy  = q_item.x_den != '0 && q_item.y_den != '0;
      bk_in.big    = q_item.x_den[MAG_W-1:31] != '0 || q_item.y_den[MAG_W-1:31] != '0;
      bk_in.x_lo   = q_item.x_den[30:0];
      bk_in.y_lo   = q_item.y_den[30:0];
      bk_in.x_neg  = q_item.x_neg;
      bk_in.y_neg  = q_item.y_neg;
   end

   bic_div u_div_x (
      .clock (clock),
      .adv   (adv),
      .num   (q_item.x_num),
      .den   (q_item.x_den),
      .quo   (qu)
   );

   bic_div u_div_y (
      .clock (clock),
      .adv   (adv),
      .num   (q_item.y_num),
      .den   (q_item.y_den),
      .quo   (qv)
   );

   // Item data line matched to divider latency
   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff[0] <= bk_in;
         for (int k = 1; k < DIV_LAT; k++) pl_ff[k] <= pl_ff[k-1];
      end
   end

   // M0: signed ratios
   always_ff @(posedge clock) begin
      if (adv) begin
         m0_bk_ff <= pl_ff[DIV_LAT-1];
         m0_u_ff  <= pl_ff[DIV_LAT-1].x_neg ? -$signed({1'b0, qu}) : $signed({1'b0, qu});
         m0_v_ff  <= pl_ff[DIV_LAT-1].y_neg ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
      end
   end

   // M1: products
   always_ff @(posedge clock) begin
      if (adv) begin
         m1_bypass_ff <= m0_bk_ff.bypass;
         m1_flag_ff   <= m0_bk_ff.flag;
         m1_g0_ff     <= m0_bk_ff.g0;
         m1_gs_ff     <= m0_bk_ff.gs;
         m1_use_u_ff  <= m0_bk_ff.use_u;
         m1_use_v_ff  <= m0_bk_ff.use_v;
         m1_nz_ff     <= m0_bk_ff.nz_xy;
         m1_big_ff    <= m0_bk_ff.big;
         m1_pu_ff     <= m0_bk_ff.d30 * m0_u_ff;
         m1_pv_ff     <= m0_bk_ff.d10 * m0_v_ff;
         m1_uvp_ff    <= m0_u_ff * m0_v_ff;
         m1_tp_ff     <= 62'(m0_bk_ff.x_lo) * 62'(m0_bk_ff.y_lo);
      end
   end

   // M2: rounding to sample format, cross-term gate
   always_comb begin
      tu_r   = rnd_frac(64'(m1_pu_ff));
      tv_r   = rnd_frac(64'(m1_pv_ff));
      uv_r   = rnd_frac(64'(m1_uvp_ff));
      use_uv = m1_nz_ff && (m1_big_ff || 64'(m1_tp_ff) >= TINY_SQ);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_bypass_ff <= m1_bypass_ff;
         m2_flag_ff   <= m1_flag_ff;
         m2_g0_ff     <= m1_g0_ff;
         m2_gs_ff     <= m1_gs_ff;
         m2_tu_ff     <= m1_use_u_ff ? tu_r[TU_W-1:0] : '0;
         m2_tv_ff     <= m1_use_v_ff ? tv_r[TU_W-1:0] : '0;
         m2_uv_ff     <= use_uv ? uv_r[UV_W-1:0] : '0;
      end
   end

   // M3: cross-term product, partial sum
   always_ff @(posedge clock) begin
      if (adv) begin
         m3_bypass_ff <= m2_bypass_ff;
         m3_flag_ff   <= m2_flag_ff;
         m3_g0_ff     <= m2_g0_ff;
         m3_s1_ff     <= S_W'(m2_g0_ff) + S_W'(m2_tu_ff) + S_W'(m2_tv_ff);
         m3_pw_ff     <= 64'(m2_gs_ff) * 64'(m2_uv_ff);
      end
   end

   // Output: final sum and saturation
   always_comb begin
      tw_r = rnd_frac(m3_pw_ff);
      res  = (S_W+1)'(m3_s1_ff) + tw_r[S_W:0];
      if (res > (S_W+1)'(33'sd2147483647))
         res_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      else if (res < -(S_W+1)'(33'sd2147483648))
         res_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      else
         res_sat = res[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_value_ff <= m3_bypass_ff ? m3_g0_ff : res_sat;
         rsp_flag_ff  <= m3_flag_ff;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) pv_ff[k] <= 1'b0;
         m0_valid_ff  <= 1'b0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         m3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         pv_ff[0] <= q_pop;
         for (int k = 1; k < DIV_LAT; k++) pv_ff[k] <= pv_ff[k-1];
         m0_valid_ff  <= pv_ff[DIV_LAT-1];
         m1_valid_ff  <= m0_valid_ff;
         m2_valid_ff  <= m1_valid_ff;
         m3_valid_ff  <= m2_valid_ff;
         rsp_valid_ff <= m3_valid_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_interpolated_value = rsp_value_ff;
   assign rsp_all_corners_bad    = rsp_flag_ff;

endmodule

`default_nettype wire
